// ===== rtl/trsq_pkg.sv =====
package trsq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TIME_W   = 32;
	localparam int TAG_W    = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POLL   = 1'b1
	} op_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_value;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t item;
	} cell_cmd_t;

	typedef struct packed {
		logic             released;
		logic             accepted;
		logic [TAG_W-1:0] current_tag;
		logic             current_valid;
		logic [CNT_W-1:0] queue_count;
	} rsp_t;

endpackage

// ===== rtl/trsq_ifs.sv =====
interface trsq_cmd_if;
	logic                          valid;
	logic                          ready;
	trsq_pkg::op_t                 operation;
	logic [trsq_pkg::TIME_W-1:0]   time_value;
	logic [trsq_pkg::TAG_W-1:0]    program_tag;

	modport source (output valid, operation, time_value, program_tag, input ready);
	modport sink   (input valid, operation, time_value, program_tag, output ready);
endinterface

interface trsq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          released;
	logic                          accepted;
	logic [trsq_pkg::TAG_W-1:0]    current_tag;
	logic                          current_valid;
	logic [trsq_pkg::CNT_W-1:0]    queue_count;

	modport source (output valid, released, accepted, current_tag, current_valid, queue_count,
		input ready);
	modport sink   (input valid, released, accepted, current_tag, current_valid, queue_count,
		output ready);
endinterface

// ===== rtl/trsq_cell.sv =====
module trsq_cell (
	input  logic                clk,
	input  trsq_pkg::cell_cmd_t cmd,
	input  logic                occ,
	input  logic                left_after,
	input  trsq_pkg::entry_t    left,
	input  trsq_pkg::entry_t    right,
	output logic                after,
	output trsq_pkg::entry_t    data
);
	import trsq_pkg::*;

	entry_t data_q;

	assign after = occ && (data_q.time_value <= cmd.item.time_value);
	assign data  = data_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && !after) begin
			data_q <= left_after ? cmd.item : left;
		end else if (cmd.pop) begin
			data_q <= right;
		end
	end

endmodule

// ===== rtl/timed_release_sorted_queue_top.sv =====
// Timed release sorted queue.
// cmd channel: words carry operation, time_value and program_tag. An insert
// stores a release time and tag, placed after every stored entry of equal or
// smaller time; a poll carries the current time and releases the head entry
// when its time is at or below it.
// rsp channel: exactly one word per cmd word, in order: released, accepted,
// current_tag, current_valid and queue_count after that command.
// Storage is a row of CAPACITY cells; each cell compares its time with the
// incoming one and keeps, takes the new entry or takes its left neighbor on
// insert, and takes its right neighbor on release; all cells update together.
// The response word is registered: it appears in the cycle after the command is taken.
// Throughput: one command per cycle; cmd.ready stays high while the response
// register is empty or being drained in the same cycle.
// When rsp.ready is low with a response pending, cmd.ready drops and the
// queue holds. Reset empties the queue and clears the current tag and its
// valid flag; no clearing pass runs.
module timed_release_sorted_queue_top (
	input  logic       clk,
	input  logic       arst_n,
	trsq_cmd_if.sink   cmd,
	trsq_rsp_if.source rsp
);
	import trsq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [TAG_W-1:0] last_tag_q;
	logic             last_valid_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	entry_t    cell_data  [CAPACITY];
	logic      cell_after [CAPACITY];
	cell_cmd_t cell_cmd;

	logic             take;
	logic             is_poll;
	logic             full;
	logic             do_ins;
	logic             do_pop;
	logic [CNT_W-1:0] count_d;
	logic [TAG_W-1:0] last_tag_d;
	logic             last_valid_d;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign take      = cmd.valid && cmd.ready;
	assign is_poll   = (cmd.operation == OP_POLL);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign do_ins    = take && !is_poll && !full;
	assign do_pop    = take && is_poll && (count_q != '0)
		&& (cell_data[0].time_value <= cmd.time_value);

	assign cell_cmd.ins             = do_ins;
	assign cell_cmd.pop             = do_pop;
	assign cell_cmd.item.time_value = cmd.time_value;
	assign cell_cmd.item.tag        = cmd.program_tag;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   occ;
		logic   l_after;
		entry_t l_data;
		entry_t r_data;

		assign occ = (count_q > CNT_W'(i));
		if (i == 0) begin : g_first
			assign l_after = 1'b1;
			assign l_data  = cell_cmd.item;
		end else begin : g_mid
			assign l_after = cell_after[i-1];
			assign l_data  = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign r_data = cell_data[i];
		end else begin : g_inner
			assign r_data = cell_data[i+1];
		end

		trsq_cell u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.occ        (occ),
			.left_after (l_after),
			.left       (l_data),
			.right      (r_data),
			.after      (cell_after[i]),
			.data       (cell_data[i])
		);
	end

	always_comb begin
		count_d      = count_q;
		last_tag_d   = last_tag_q;
		last_valid_d = last_valid_q;
		if (do_ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_pop) begin
			count_d      = count_q - CNT_W'(1);
			last_tag_d   = cell_data[0].tag;
			last_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			last_tag_q   <= '0;
			last_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				count_q      <= count_d;
				last_tag_q   <= last_tag_d;
				last_valid_q <= last_valid_d;
				rsp_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.released      <= do_pop;
			rsp_q.accepted      <= do_ins;
			rsp_q.current_tag   <= last_tag_d;
			rsp_q.current_valid <= last_valid_d;
			rsp_q.queue_count   <= count_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.released      = rsp_q.released;
	assign rsp.accepted      = rsp_q.accepted;
	assign rsp.current_tag   = rsp_q.current_tag;
	assign rsp.current_valid = rsp_q.current_valid;
	assign rsp.queue_count   = rsp_q.queue_count;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("queue count above capacity");

	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.released && rsp_q.accepted))
		else $error("response both released and accepted");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not advance count");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> (count_q == $past(count_q) - CNT_W'(1)) && last_valid_q)
		else $error("release did not drop count");

	a_rsp_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.queue_count == count_q)
		else $error("pending response count out of step");

endmodule
